### design/grgp_pkg.sv
// shared types, widths and codes of the ground ray grid projector
package grgp_pkg;

  localparam int COORD_W_DEF = 12;
  localparam int FIELD_W     = 12;
  localparam int H_W         = 14;
  localparam int F_W         = 24;
  localparam int R_W         = 16;
  localparam int XC_W        = H_W + F_W;
  localparam int FRAC_SH     = 25;
  localparam int ACC_W       = 56;
  localparam int D_W         = ACC_W - FRAC_SH;
  localparam int POS_W       = 16;
  localparam int CPM_W       = 16;
  localparam int XM_W        = POS_W + CPM_W + 1;
  localparam int TX_W        = D_W + POS_W + 1;
  localparam int PX_W        = XM_W + 2;
  localparam int LIM_W       = FIELD_W + D_W;
  localparam int QSH         = 17;
  localparam int Q_W         = D_W + QSH;
  localparam int WIDE_W      = 64;
  localparam int REM_W       = WIDE_W - 1;
  localparam int CELL_W      = 12;
  localparam int IDX_W       = 24;
  localparam int STAT_W      = 3;
  localparam int REG_W       = 48;
  localparam int PDATA_W     = 64;
  localparam int PADDR_W     = 6;

  typedef enum logic [STAT_W-1:0] {
    ST_FREE       = 3'd0,
    ST_NOT_GROUND = 3'd1,
    ST_OUT_MASK   = 3'd2,
    ST_NOT_FWD    = 3'd3,
    ST_OUT_GRID   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_ROT0  = 3'd0,
    REG_ROT1  = 3'd1,
    REG_ROT2  = 3'd2,
    REG_CAM   = 3'd3,
    REG_FOCAL = 3'd4,
    REG_CPM   = 3'd5,
    REG_SIZES = 3'd6
  } reg_e;

  typedef struct packed {
    logic [REG_W-1:0] rot0;
    logic [REG_W-1:0] rot1;
    logic [REG_W-1:0] rot2;
    logic [REG_W-1:0] cam;
    logic [REG_W-1:0] focal;
    logic [CPM_W-1:0] cpm;
    logic [REG_W-1:0] sizes;
  } cfg_t;

endpackage

### design/ground_ray_grid_projector.sv
// top level of the ground ray grid projector: registers, pipeline and result beat
//
// Projects segmentation-mask pixels onto a ground occupancy grid. Each input
// beat (pixel_col_i, pixel_row_i, class_label_i) gives exactly one output beat
// (cell_x_o, cell_y_o, cell_index_o, status_o); status tells whether the cell
// may be marked free or why not (not ground, outside mask, ray not forward,
// outside grid), and the cell fields are zero unless it is free.
// Both channels use valid/ready. Pose, focal reciprocals, scale and frame sizes
// sit in an APB-style register file, 64-bit data, register i at byte 8*i;
// write them only while no beat is in flight.
// The path from input beat to output beat runs through four stages of ray
// and rotation, five of intersection terms, twelve of the divider that
// produces one quotient bit per stage, and the output register.
// Throughput is one beat per cycle while results are taken; the divider is fully pipelined.
// All stages advance together; when the output register holds an untaken
// beat the whole pipeline holds and in_ready_o drops, nothing is lost.
// Reset clears every valid bit and the register file to zero, so the first
// results before any configuration report outside mask.
module ground_ray_grid_projector #(
  parameter int COORD_BITS = grgp_pkg::COORD_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel beats
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [COORD_BITS-1:0]             pixel_col_i,
  input  logic [COORD_BITS-1:0]             pixel_row_i,
  input  logic [15:0]                       class_label_i,
  // result beats
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [grgp_pkg::CELL_W-1:0]       cell_x_o,
  output logic [grgp_pkg::CELL_W-1:0]       cell_y_o,
  output logic [grgp_pkg::IDX_W-1:0]        cell_index_o,
  output logic [grgp_pkg::STAT_W-1:0]       status_o,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [grgp_pkg::PADDR_W-1:0]      paddr,
  input  logic [grgp_pkg::PDATA_W-1:0]      pwdata,
  output logic [grgp_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  // register file, all reset to zero
  logic [grgp_pkg::REG_W-1:0] rot0_q, rot1_q, rot2_q, cam_q, focal_q, sizes_q;
  logic [grgp_pkg::CPM_W-1:0] cpm_q;
  logic                       wr_en;
  logic [2:0]                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[grgp_pkg::PADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot0_q  <= '0;
      rot1_q  <= '0;
      rot2_q  <= '0;
      cam_q   <= '0;
      focal_q <= '0;
      cpm_q   <= '0;
      sizes_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        grgp_pkg::REG_ROT0:  rot0_q  <= pwdata[grgp_pkg::REG_W-1:0];
        grgp_pkg::REG_ROT1:  rot1_q  <= pwdata[grgp_pkg::REG_W-1:0];
        grgp_pkg::REG_ROT2:  rot2_q  <= pwdata[grgp_pkg::REG_W-1:0];
        grgp_pkg::REG_CAM:   cam_q   <= pwdata[grgp_pkg::REG_W-1:0];
        grgp_pkg::REG_FOCAL: focal_q <= pwdata[grgp_pkg::REG_W-1:0];
        grgp_pkg::REG_CPM:   cpm_q   <= pwdata[grgp_pkg::CPM_W-1:0];
        grgp_pkg::REG_SIZES: sizes_q <= pwdata[grgp_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      grgp_pkg::REG_ROT0:  prdata = grgp_pkg::PDATA_W'(rot0_q);
      grgp_pkg::REG_ROT1:  prdata = grgp_pkg::PDATA_W'(rot1_q);
      grgp_pkg::REG_ROT2:  prdata = grgp_pkg::PDATA_W'(rot2_q);
      grgp_pkg::REG_CAM:   prdata = grgp_pkg::PDATA_W'(cam_q);
      grgp_pkg::REG_FOCAL: prdata = grgp_pkg::PDATA_W'(focal_q);
      grgp_pkg::REG_CPM:   prdata = grgp_pkg::PDATA_W'(cpm_q);
      grgp_pkg::REG_SIZES: prdata = grgp_pkg::PDATA_W'(sizes_q);
      default:             prdata = '0;
    endcase
  end

  grgp_pkg::cfg_t cfg;
  assign cfg.rot0  = rot0_q;
  assign cfg.rot1  = rot1_q;
  assign cfg.rot2  = rot2_q;
  assign cfg.cam   = cam_q;
  assign cfg.focal = focal_q;
  assign cfg.cpm   = cpm_q;
  assign cfg.sizes = sizes_q;

  logic [grgp_pkg::FIELD_W-1:0] gw, gh;
  assign gw = sizes_q[35:24];
  assign gh = sizes_q[47:36];

  // one enable for every stage: move unless the result beat is stuck
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic                            ray_valid;
  grgp_pkg::status_e               ray_status;
  logic signed [grgp_pkg::D_W-1:0] d0, d1, d2;

  grgp_ray #(
    .COORD_BITS(COORD_BITS)
  ) u_ray (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .class_label_i(class_label_i),
    .cfg_i        (cfg),
    .valid_o      (ray_valid),
    .status_o     (ray_status),
    .d0_o         (d0),
    .d1_o         (d1),
    .d2_o         (d2)
  );

  logic                        prj_valid;
  grgp_pkg::status_e           prj_status;
  logic [grgp_pkg::REM_W-1:0]  ax, ay;
  logic [grgp_pkg::Q_W-1:0]    q;

  grgp_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ray_valid),
    .status_i(ray_status),
    .d0_i    (d0),
    .d1_i    (d1),
    .d2_i    (d2),
    .cfg_i   (cfg),
    .valid_o (prj_valid),
    .status_o(prj_status),
    .ax_o    (ax),
    .ay_o    (ay),
    .q_o     (q)
  );

  logic                         div_valid;
  grgp_pkg::status_e            div_status;
  logic [grgp_pkg::CELL_W-1:0]  gx, gy;

  grgp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prj_valid),
    .status_i(prj_status),
    .ax_i    (ax),
    .ay_i    (ay),
    .q_i     (q),
    .valid_o (div_valid),
    .status_o(div_status),
    .gx_o    (gx),
    .gy_o    (gy)
  );

  // output register: row-major index, cell fields zeroed unless free
  logic [grgp_pkg::CELL_W-1:0] cx_d, cy_d, cx_q, cy_q;
  logic [grgp_pkg::IDX_W-1:0]  idx_d, idx_q;
  grgp_pkg::status_e           st_q;
  logic                        is_free;

  always_comb begin
    is_free = (div_status == grgp_pkg::ST_FREE);
    cx_d    = is_free ? gx : '0;
    cy_d    = is_free ? gy : '0;
    idx_d   = is_free
            ? (grgp_pkg::IDX_W'(gy) * grgp_pkg::IDX_W'(gw) + grgp_pkg::IDX_W'(gx)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      idx_q <= idx_d;
      st_q  <= div_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_x_o     = cx_q;
  assign cell_y_o     = cy_q;
  assign cell_index_o = idx_q;
  assign status_o     = st_q;

  // cell fields only carry data on a free result
  a_zero_unless_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != grgp_pkg::ST_FREE
    |-> cell_x_o == '0 && cell_y_o == '0 && cell_index_o == '0)
    else $error("cell fields set on a non-free result");

  // a free cell lies inside the grid
  a_free_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == grgp_pkg::ST_FREE |-> cell_x_o < gw && cell_y_o < gh)
    else $error("free cell outside the grid");

  // index stays below the cell count
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == grgp_pkg::ST_FREE
    |-> cell_index_o < (grgp_pkg::IDX_W'(gw) * grgp_pkg::IDX_W'(gh)))
    else $error("cell index beyond the grid");

endmodule

### design/grgp_ray.sv
// mask checks, camera ray and rotated direction (four stages)
module grgp_ray #(
  parameter int COORD_BITS = grgp_pkg::COORD_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [COORD_BITS-1:0]             pixel_col_i,
  input  logic [COORD_BITS-1:0]             pixel_row_i,
  input  logic [15:0]                       class_label_i,
  input  grgp_pkg::cfg_t                    cfg_i,
  output logic                              valid_o,
  output grgp_pkg::status_e                 status_o,
  output logic signed [grgp_pkg::D_W-1:0]   d0_o,
  output logic signed [grgp_pkg::D_W-1:0]   d1_o,
  output logic signed [grgp_pkg::D_W-1:0]   d2_o
);

  localparam int CMP_W = (COORD_BITS > grgp_pkg::FIELD_W) ? COORD_BITS : grgp_pkg::FIELD_W;

  logic [grgp_pkg::FIELD_W-1:0] mw, mh;
  logic [CMP_W-1:0] col_w, row_w;
  logic [grgp_pkg::FIELD_W-1:0] col12, row12;
  assign mw    = cfg_i.sizes[11:0];
  assign mh    = cfg_i.sizes[23:12];
  assign col_w = CMP_W'(pixel_col_i);
  assign row_w = CMP_W'(pixel_row_i);
  assign col12 = col_w[grgp_pkg::FIELD_W-1:0];
  assign row12 = row_w[grgp_pkg::FIELD_W-1:0];

  // stage 1: mask and label tests, half-pixel offsets
  logic v1_q, v2_q, v3_q, v4_q;
  grgp_pkg::status_e st1_d, st1_q, st2_q, st3_q, st4_q;
  logic signed [grgp_pkg::H_W-1:0] hx1_d, hy1_d, hx1_q, hy1_q;

  always_comb begin
    if (col_w >= CMP_W'(mw) || row_w >= CMP_W'(mh)) begin
      st1_d = grgp_pkg::ST_OUT_MASK;
    end else if (class_label_i != '0) begin
      st1_d = grgp_pkg::ST_NOT_GROUND;
    end else begin
      st1_d = grgp_pkg::ST_FREE;
    end
    hx1_d = $signed({1'b0, col12, 1'b1}) - $signed({2'b00, mw});
    hy1_d = $signed({1'b0, row12, 1'b1}) - $signed({2'b00, mh});
  end

  // stage 2: camera ray in q.25
  logic signed [grgp_pkg::XC_W-1:0] xc2_d, yc2_d, xc2_q, yc2_q;
  assign xc2_d = hx1_q * $signed({1'b0, cfg_i.focal[23:0]});
  assign yc2_d = hy1_q * $signed({1'b0, cfg_i.focal[47:24]});

  // stage 3: rotation products, third column handled as a shift
  logic signed [grgp_pkg::ACC_W-1:0] p0_d [3];
  logic signed [grgp_pkg::ACC_W-1:0] p1_d [3];
  logic signed [grgp_pkg::ACC_W-1:0] p0_q [3];
  logic signed [grgp_pkg::ACC_W-1:0] p1_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0_d[k] = $signed(cfg_i.rot0[grgp_pkg::R_W*k +: grgp_pkg::R_W]) * xc2_q;
      p1_d[k] = $signed(cfg_i.rot1[grgp_pkg::R_W*k +: grgp_pkg::R_W]) * yc2_q;
    end
  end

  // stage 4: sum and floor to q.14
  logic signed [grgp_pkg::ACC_W-1:0] acc [3];
  logic signed [grgp_pkg::D_W-1:0]   d4_d [3];
  logic signed [grgp_pkg::D_W-1:0]   d4_q [3];
  logic [grgp_pkg::R_W-1:0]          r2 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r2[k]   = cfg_i.rot2[grgp_pkg::R_W*k +: grgp_pkg::R_W];
      acc[k]  = p0_q[k] + p1_q[k]
              + $signed({{(grgp_pkg::ACC_W-grgp_pkg::R_W-grgp_pkg::FRAC_SH){r2[k][grgp_pkg::R_W-1]}},
                         r2[k], {grgp_pkg::FRAC_SH{1'b0}}});
      d4_d[k] = acc[k][grgp_pkg::ACC_W-1:grgp_pkg::FRAC_SH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st1_q <= st1_d;
      hx1_q <= hx1_d;
      hy1_q <= hy1_d;
      st2_q <= st1_q;
      xc2_q <= xc2_d;
      yc2_q <= yc2_d;
      st3_q <= st2_q;
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      st4_q <= st3_q;
      d4_q  <= d4_d;
    end
  end

  assign valid_o  = v4_q;
  assign status_o = st4_q;
  assign d0_o     = d4_q[0];
  assign d1_o     = d4_q[1];
  assign d2_o     = d4_q[2];

endmodule

### design/grgp_proj.sv
// ground intersection terms, dividend and divisor per axis (five stages)
module grgp_proj (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  grgp_pkg::status_e                 status_i,
  input  logic signed [grgp_pkg::D_W-1:0]   d0_i,
  input  logic signed [grgp_pkg::D_W-1:0]   d1_i,
  input  logic signed [grgp_pkg::D_W-1:0]   d2_i,
  input  grgp_pkg::cfg_t                    cfg_i,
  output logic                              valid_o,
  output grgp_pkg::status_e                 status_o,
  output logic [grgp_pkg::REM_W-1:0]        ax_o,
  output logic [grgp_pkg::REM_W-1:0]        ay_o,
  output logic [grgp_pkg::Q_W-1:0]          q_o
);

  logic signed [grgp_pkg::POS_W-1:0] x0, y0, z0;
  logic [grgp_pkg::CPM_W-1:0]        cpm;
  logic [grgp_pkg::FIELD_W-1:0]      gw, gh;
  assign x0  = cfg_i.cam[15:0];
  assign y0  = cfg_i.cam[31:16];
  assign z0  = cfg_i.cam[47:32];
  assign cpm = cfg_i.cpm;
  assign gw  = cfg_i.sizes[35:24];
  assign gh  = cfg_i.sizes[47:36];

  logic v5_q, v6_q, v7_q, v8_q, v9_q;
  grgp_pkg::status_e st5_d, st5_q, st6_q, st7_q, st8_q, st9_d, st9_q;

  // stage 5: forward test, magnitudes, position times scale
  logic                                nf;
  logic [grgp_pkg::POS_W-1:0]          za5_d, za5_q;
  logic [grgp_pkg::D_W-1:0]            da5_d, da5_q;
  logic signed [grgp_pkg::XM_W-1:0]    xm5_d, ym5_d, xm5_q, ym5_q;
  logic signed [grgp_pkg::D_W-1:0]     d05_q, d15_q;

  always_comb begin
    nf = (z0 == '0) || (d2_i == '0)
      || ((!z0[grgp_pkg::POS_W-1]) != d2_i[grgp_pkg::D_W-1]);
    st5_d = (status_i == grgp_pkg::ST_FREE && nf) ? grgp_pkg::ST_NOT_FWD : status_i;
    za5_d = z0[grgp_pkg::POS_W-1] ? (~z0 + 1'b1) : z0;
    da5_d = d2_i[grgp_pkg::D_W-1] ? (~d2_i + 1'b1) : d2_i;
    xm5_d = x0 * $signed({1'b0, cpm});
    ym5_d = y0 * $signed({1'b0, cpm});
  end

  // stage 6: ray term, grid offset term, bounds
  logic signed [grgp_pkg::TX_W-1:0]  tx6_d, ty6_d, tx6_q, ty6_q;
  logic signed [grgp_pkg::PX_W-1:0]  px6_d, py6_d, px6_q, py6_q;
  logic [grgp_pkg::LIM_W-1:0]        lx6_d, ly6_d, lx6_q, ly6_q;
  logic [grgp_pkg::D_W-1:0]          da6_q;

  always_comb begin
    tx6_d = d05_q * $signed({1'b0, za5_q});
    ty6_d = d15_q * $signed({1'b0, za5_q});
    px6_d = $signed({xm5_q[grgp_pkg::XM_W-1], xm5_q, 1'b0}) + $signed({7'd0, gw, 16'd0});
    py6_d = $signed({ym5_q[grgp_pkg::XM_W-1], ym5_q, 1'b0}) + $signed({7'd0, gh, 16'd0});
    lx6_d = grgp_pkg::LIM_W'(gw) * grgp_pkg::LIM_W'(da5_q);
    ly6_d = grgp_pkg::LIM_W'(gh) * grgp_pkg::LIM_W'(da5_q);
  end

  // stage 7: wide products, wrapping at 64 bits
  logic signed [grgp_pkg::WIDE_W-1:0] m1x7_d, m1y7_d, m2x7_d, m2y7_d;
  logic signed [grgp_pkg::WIDE_W-1:0] m1x7_q, m1y7_q, m2x7_q, m2y7_q;
  logic [grgp_pkg::LIM_W-1:0]         lx7_q, ly7_q;
  logic [grgp_pkg::D_W-1:0]           da7_q;

  always_comb begin
    m1x7_d = $signed({1'b0, da6_q}) * px6_q;
    m1y7_d = $signed({1'b0, da6_q}) * py6_q;
    m2x7_d = tx6_q * $signed({1'b0, cpm});
    m2y7_d = ty6_q * $signed({1'b0, cpm});
  end

  // stage 8: dividend and divisor
  logic signed [grgp_pkg::WIDE_W-1:0] ax8_d, ay8_d, ax8_q, ay8_q;
  logic [grgp_pkg::Q_W-1:0]           q8_q, q9_q;
  logic [grgp_pkg::LIM_W-1:0]         lx8_q, ly8_q;

  assign ax8_d = m1x7_q + (m2x7_q <<< 1);
  assign ay8_d = m1y7_q + (m2y7_q <<< 1);

  // stage 9: grid range test, quotient must land in [0, size)
  logic [grgp_pkg::REM_W-1:0] limx, limy;
  logic ogx, ogy;
  logic [grgp_pkg::REM_W-1:0] ax9_q, ay9_q;

  always_comb begin
    limx  = grgp_pkg::REM_W'({lx8_q, {grgp_pkg::QSH{1'b0}}});
    limy  = grgp_pkg::REM_W'({ly8_q, {grgp_pkg::QSH{1'b0}}});
    ogx   = ax8_q[grgp_pkg::WIDE_W-1] || (ax8_q[grgp_pkg::REM_W-1:0] >= limx);
    ogy   = ay8_q[grgp_pkg::WIDE_W-1] || (ay8_q[grgp_pkg::REM_W-1:0] >= limy);
    st9_d = (st8_q == grgp_pkg::ST_FREE && (ogx || ogy)) ? grgp_pkg::ST_OUT_GRID : st8_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st5_q  <= st5_d;
      za5_q  <= za5_d;
      da5_q  <= da5_d;
      xm5_q  <= xm5_d;
      ym5_q  <= ym5_d;
      d05_q  <= d0_i;
      d15_q  <= d1_i;
      st6_q  <= st5_q;
      tx6_q  <= tx6_d;
      ty6_q  <= ty6_d;
      px6_q  <= px6_d;
      py6_q  <= py6_d;
      lx6_q  <= lx6_d;
      ly6_q  <= ly6_d;
      da6_q  <= da5_q;
      st7_q  <= st6_q;
      m1x7_q <= m1x7_d;
      m1y7_q <= m1y7_d;
      m2x7_q <= m2x7_d;
      m2y7_q <= m2y7_d;
      lx7_q  <= lx6_q;
      ly7_q  <= ly6_q;
      da7_q  <= da6_q;
      st8_q  <= st7_q;
      ax8_q  <= ax8_d;
      ay8_q  <= ay8_d;
      q8_q   <= {da7_q, {grgp_pkg::QSH{1'b0}}};
      lx8_q  <= lx7_q;
      ly8_q  <= ly7_q;
      st9_q  <= st9_d;
      ax9_q  <= ax8_q[grgp_pkg::REM_W-1:0];
      ay9_q  <= ay8_q[grgp_pkg::REM_W-1:0];
      q9_q   <= q8_q;
    end
  end

  assign valid_o  = v9_q;
  assign status_o = st9_q;
  assign ax_o     = ax9_q;
  assign ay_o     = ay9_q;
  assign q_o      = q9_q;

endmodule

### design/grgp_div.sv
// pipelined restoring divider, one quotient bit per stage, x and y lanes
module grgp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  grgp_pkg::status_e           status_i,
  input  logic [grgp_pkg::REM_W-1:0]  ax_i,
  input  logic [grgp_pkg::REM_W-1:0]  ay_i,
  input  logic [grgp_pkg::Q_W-1:0]    q_i,
  output logic                        valid_o,
  output grgp_pkg::status_e           status_o,
  output logic [grgp_pkg::CELL_W-1:0] gx_o,
  output logic [grgp_pkg::CELL_W-1:0] gy_o
);

  localparam int NS = grgp_pkg::CELL_W;

  logic [NS-1:0]                valid_q;
  grgp_pkg::status_e            st_q  [NS];
  logic [grgp_pkg::REM_W-1:0]   rx_q  [NS];
  logic [grgp_pkg::REM_W-1:0]   ry_q  [NS];
  logic [grgp_pkg::Q_W-1:0]     q_q   [NS];
  logic [grgp_pkg::CELL_W-1:0]  qx_q  [NS];
  logic [grgp_pkg::CELL_W-1:0]  qy_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic                        v_in;
    grgp_pkg::status_e           st_in;
    logic [grgp_pkg::REM_W-1:0]  rx_in, ry_in, sub, rx_d, ry_d;
    logic [grgp_pkg::Q_W-1:0]    q_in;
    logic [grgp_pkg::CELL_W-1:0] qx_in, qy_in, qx_d, qy_d;
    logic                        gex, gey;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign st_in = status_i;
      assign rx_in = ax_i;
      assign ry_in = ay_i;
      assign q_in  = q_i;
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign v_in  = valid_q[s-1];
      assign st_in = st_q[s-1];
      assign rx_in = rx_q[s-1];
      assign ry_in = ry_q[s-1];
      assign q_in  = q_q[s-1];
      assign qx_in = qx_q[s-1];
      assign qy_in = qy_q[s-1];
    end

    always_comb begin
      sub     = grgp_pkg::REM_W'(q_in) << B;
      gex     = rx_in >= sub;
      gey     = ry_in >= sub;
      rx_d    = gex ? (rx_in - sub) : rx_in;
      ry_d    = gey ? (ry_in - sub) : ry_in;
      qx_d    = qx_in;
      qy_d    = qy_in;
      qx_d[B] = gex;
      qy_d[B] = gey;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_in;
        rx_q[s] <= rx_d;
        ry_q[s] <= ry_d;
        q_q[s]  <= q_in;
        qx_q[s] <= qx_d;
        qy_q[s] <= qy_d;
      end
    end
  end

  assign valid_o  = valid_q[NS-1];
  assign status_o = st_q[NS-1];
  assign gx_o     = qx_q[NS-1];
  assign gy_o     = qy_q[NS-1];

endmodule
